>>> rtl/core/cmcl_pkg.sv
// Shared types and constants for the contrastive loss core.
// Used by cmcl_itu and cross_modal_contrastive_loss_core; no dependencies.
package cmcl_pkg;

  typedef struct packed {
    logic [2:0]         req_type;
    logic [5:0]         row;
    logic [6:0]         col;
    logic signed [15:0] value;
  } req_t;

  typedef struct packed {
    logic               is_loss;
    logic [47:0]        loss_value;
    logic signed [31:0] gradient_value;
  } res_t;

  typedef enum logic [2:0] {
    REQ_LOAD_IMG = 3'd0,
    REQ_LOAD_TXT = 3'd1,
    REQ_LOAD_LBL = 3'd2,
    REQ_FORWARD  = 3'd3,
    REQ_BACKWARD = 3'd4,
    REQ_READ_IMG = 3'd5,
    REQ_READ_TXT = 3'd6,
    REQ_NONE     = 3'd7
  } req_code_t;

  localparam logic [1:0] CFG_MARGIN   = 2'd0;
  localparam logic [1:0] CFG_BATCH    = 2'd1;
  localparam logic [1:0] CFG_DIM      = 2'd2;
  localparam logic [1:0] CFG_TEXT_EN  = 2'd3;

  localparam logic [32:0] EPS_Q24     = 33'd1678;

  typedef enum logic {
    ITU_DIV  = 1'b0,
    ITU_SQRT = 1'b1
  } itu_op_t;

  localparam logic [5:0] ITU_DIV_LAST  = 6'd63;
  localparam logic [5:0] ITU_SQRT_LAST = 6'd31;

  typedef enum logic [4:0] {
    ST_CLR, ST_IDLE, ST_LI, ST_LJ, ST_SIM,
    ST_FRD, ST_FMUL, ST_FADD, ST_FST,
    ST_SQW, ST_GAP, ST_FGSQ, ST_FGADD,
    ST_BDEN, ST_BDEN2, ST_BRD, ST_BD, ST_BM, ST_BDIV, ST_BDW, ST_BACC,
    ST_NEXT, ST_LDW
  } state_t;

  function automatic logic [31:0] sat32(input logic signed [65:0] v);
    if (v > 66'sd2147483647) return 32'h7fff_ffff;
    if (v < -66'sd2147483648) return 32'h8000_0000;
    return v[31:0];
  endfunction

endpackage

>>> rtl/core/cmcl_itu.sv
// Shared iterative unit: 64/64 restoring divide or 64-bit integer square root.
// One compare/subtract per cycle. Depends on cmcl_pkg.
module cmcl_itu (
  input  logic              clk,
  input  logic              rst,
  input  logic              go,
  input  cmcl_pkg::itu_op_t op,
  input  logic [63:0]       a,
  input  logic [63:0]       b,
  output logic              done,
  output logic [63:0]       y
);
  import cmcl_pkg::*;

  logic        run;
  logic [5:0]  cnt;
  itu_op_t     op_r;
  logic [63:0] x, r, bitm, den;
  logic [64:0] rem, remsh, lhs, rhs;
  logic [65:0] diff;
  logic        ge;

  always_comb begin
    remsh = {rem[63:0], x[63]};
    if (op_r == ITU_SQRT) begin
      lhs = {1'b0, x};
      rhs = {1'b0, r} + {1'b0, bitm};
    end else begin
      lhs = remsh;
      rhs = {1'b0, den};
    end
    diff = {1'b0, lhs} - {1'b0, rhs};
    ge   = ~diff[65];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (go) begin
        run  <= 1'b1;
        op_r <= op;
        x    <= a;
        den  <= b;
        rem  <= '0;
        r    <= '0;
        bitm <= 64'h4000_0000_0000_0000;
        cnt  <= (op == ITU_SQRT) ? ITU_SQRT_LAST : ITU_DIV_LAST;
      end else if (run) begin
        if (op_r == ITU_SQRT) begin
          if (ge) begin
            x <= diff[63:0];
            r <= (r >> 1) + bitm;
          end else begin
            r <= r >> 1;
          end
          bitm <= bitm >> 2;
        end else begin
          x <= x << 1;
          if (ge) begin
            rem <= diff[64:0];
            r   <= {r[62:0], 1'b1};
          end else begin
            rem <= remsh;
            r   <= {r[62:0], 1'b0};
          end
        end
        if (cnt == '0) begin
          run  <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt - 6'd1;
        end
      end
    end
  end

  assign y = r;

endmodule

>>> rtl/core/cross_modal_contrastive_loss_core.sv
// Contrastive loss with margin over image/text feature batches, Q4.12 fixed point.
// Top level: sequencer, feature/label/distance/gradient memories. Uses cmcl_pkg, cmcl_itu.
//
//   channel  signals                                  dir  request when
//   req      start, busy, req                         in   start && !busy
//   res      done, res                                out  done (one cycle)
//   cfg      cfg_valid, cfg_ready, cfg_index, cfg_data in  cfg_valid && cfg_ready
//
// Loads keep busy low; a gradient read result goes via rd_pend to res with done.
// Forward: visits all n*n pairs, using the shared divide/sqrt unit.
// Backward: clears all MAX_BATCH*MAX_DIM gradient entries, then visits all n*n pairs.
// After reset the gradient memories are swept to zero; busy stays high during the sweep.
// Results cannot be stalled; cfg_ready is always high.
module cross_modal_contrastive_loss_core #(
  parameter int MAX_BATCH = 64,
  parameter int MAX_DIM   = 128
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  output logic            busy,
  input  cmcl_pkg::req_t  req,
  output logic            done,
  output cmcl_pkg::res_t  res,
  input  logic            cfg_valid,
  output logic            cfg_ready,
  input  logic [1:0]      cfg_index,
  input  logic [15:0]     cfg_data
);
  import cmcl_pkg::*;

  localparam int DEPTH = MAX_BATCH * MAX_DIM;
  localparam int PAIRS = MAX_BATCH * MAX_BATCH;
  localparam int IW    = $clog2(MAX_BATCH);
  localparam int KW    = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
  localparam int AW    = $clog2(DEPTH);
  localparam int PW    = $clog2(PAIRS);
  localparam int NW    = $clog2(MAX_BATCH + 1);
  localparam int DW    = $clog2(MAX_DIM + 1);

  state_t state, state_next;

  logic [15:0] margin;
  logic [6:0]  batch_size;
  logic [7:0]  feature_dim;
  logic        text_grad_en;

  logic [NW-1:0] n_eff;
  logic [DW-1:0] d_eff;
  logic [IW-1:0] n_last, i, j;
  logic [KW-1:0] k_last_v, k;
  logic [AW-1:0] clr_addr, addr_ik, addr_jk, req_addr;
  logic [PW-1:0] pair_addr;
  logic [IW-1:0] lab_raddr;

  logic [15:0] img_mem [DEPTH];
  logic [15:0] txt_mem [DEPTH];
  logic [15:0] lab_mem [MAX_BATCH];
  logic [39:0] dsq_mem [PAIRS];
  logic [31:0] ig_mem  [DEPTH];
  logic [31:0] tg_mem  [DEPTH];

  logic [15:0] img_q, txt_q, lab_q, lab_i;
  logic [39:0] dsq_q, acc;
  logic [31:0] ig_q, tg_q;

  logic        accept, in_range, row_in;
  logic        bwd, similar, d_neg, s_neg, rd_pend, rd_txt, rd_inside;
  logic [15:0] s_abs;
  logic [63:0] sum, prod, num, den, tq;
  logic [31:0] dist_q;
  logic [27:0] gap, m24;

  logic        i_last, j_last, k_last, clr_last, sim_now, neg;
  logic signed [16:0] d;
  logic [16:0] da;
  logic [33:0] sq;
  logic [40:0] acc_add;
  logic [39:0] acc_sat;
  logic signed [65:0] t_ext, t_sgn;
  logic [31:0] ig_new, tg_new;
  logic        img_we, txt_we, lab_we, dsq_we, ig_we, tg_we;
  logic [AW-1:0] ig_raddr, tg_raddr, ig_waddr, tg_waddr;

  logic        u_go, u_done;
  itu_op_t     u_op;
  logic [63:0] u_a, u_b, u_y;

  cmcl_itu u_itu (
    .clk  (clk),
    .rst  (rst),
    .go   (u_go),
    .op   (u_op),
    .a    (u_a),
    .b    (u_b),
    .done (u_done),
    .y    (u_y)
  );

  assign cfg_ready = 1'b1;
  assign busy      = (state != ST_IDLE);
  assign accept    = start && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      margin       <= 16'd4096;
      batch_size   <= 7'd64;
      feature_dim  <= 8'd128;
      text_grad_en <= 1'b0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_MARGIN:  margin       <= cfg_data;
        CFG_BATCH:   batch_size   <= cfg_data[6:0];
        CFG_DIM:     feature_dim  <= cfg_data[7:0];
        CFG_TEXT_EN: text_grad_en <= cfg_data[0];
      endcase
    end
  end

  always_comb begin
    if (batch_size == '0) n_eff = NW'(1);
    else if (int'(batch_size) > MAX_BATCH) n_eff = NW'(MAX_BATCH);
    else n_eff = NW'(batch_size);
    if (feature_dim == '0) d_eff = DW'(1);
    else if (int'(feature_dim) > MAX_DIM) d_eff = DW'(MAX_DIM);
    else d_eff = DW'(feature_dim);
    n_last   = IW'(n_eff - NW'(1));
    k_last_v = KW'(d_eff - DW'(1));
  end

  assign m24       = {margin, 12'd0};
  assign addr_ik   = AW'(int'(i) * MAX_DIM + int'(k));
  assign addr_jk   = AW'(int'(j) * MAX_DIM + int'(k));
  assign pair_addr = PW'(int'(i) * MAX_BATCH + int'(j));
  assign req_addr  = AW'(int'(req.row) * MAX_DIM + int'(req.col));
  assign row_in    = int'(req.row) < MAX_BATCH;
  assign in_range  = row_in && (int'(req.col) < MAX_DIM);
  assign lab_raddr = (state == ST_LJ) ? j : i;

  assign i_last   = (i == n_last);
  assign j_last   = (j == n_last);
  assign k_last   = (k == k_last_v);
  assign clr_last = (clr_addr == AW'(DEPTH - 1));
  assign sim_now  = (lab_q == lab_i);

  always_comb begin
    d       = $signed({img_q[15], img_q}) - $signed({txt_q[15], txt_q});
    da      = d[16] ? 17'(-d) : 17'(d);
    sq      = da * da;
    acc_add = {1'b0, acc} + 41'(prod[33:0]);
    acc_sat = acc_add[40] ? '1 : acc_add[39:0];
    neg     = s_neg ^ d_neg ^ ~similar;
    t_ext   = $signed({2'b00, tq});
    t_sgn   = neg ? -t_ext : t_ext;
    ig_new  = sat32($signed({{34{ig_q[31]}}, ig_q}) + t_sgn);
    tg_new  = sat32($signed({{34{tg_q[31]}}, tg_q}) - t_sgn);
  end

  assign img_we   = accept && (req.req_type == REQ_LOAD_IMG) && in_range;
  assign txt_we   = accept && (req.req_type == REQ_LOAD_TXT) && in_range;
  assign lab_we   = accept && (req.req_type == REQ_LOAD_LBL) && row_in;
  assign dsq_we   = (state == ST_FST);
  assign ig_we    = (state == ST_CLR) || (state == ST_BACC);
  assign tg_we    = (state == ST_CLR) || ((state == ST_BACC) && text_grad_en);
  assign ig_waddr = (state == ST_CLR) ? clr_addr : addr_ik;
  assign tg_waddr = (state == ST_CLR) ? clr_addr : addr_jk;
  assign ig_raddr = (state == ST_IDLE) ? req_addr : addr_ik;
  assign tg_raddr = (state == ST_IDLE) ? req_addr : addr_jk;

  always_ff @(posedge clk) begin
    if (img_we) img_mem[req_addr] <= req.value;
    if (txt_we) txt_mem[req_addr] <= req.value;
    if (lab_we) lab_mem[IW'(req.row)] <= req.value;
    if (dsq_we) dsq_mem[pair_addr] <= acc;
    if (ig_we) ig_mem[ig_waddr] <= (state == ST_CLR) ? 32'd0 : ig_new;
    if (tg_we) tg_mem[tg_waddr] <= (state == ST_CLR) ? 32'd0 : tg_new;
    img_q <= img_mem[addr_ik];
    txt_q <= txt_mem[addr_jk];
    lab_q <= lab_mem[lab_raddr];
    dsq_q <= dsq_mem[pair_addr];
    ig_q  <= ig_mem[ig_raddr];
    tg_q  <= tg_mem[tg_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_CLR;
    else state <= state_next;
  end

  always_comb begin
    state_next = state;
    u_go       = 1'b0;
    u_op       = ITU_DIV;
    u_a        = '0;
    u_b        = '0;
    unique case (state)
      ST_CLR:   if (clr_last) state_next = bwd ? ST_LI : ST_IDLE;
      ST_IDLE: begin
        if (accept && (req.req_type == REQ_FORWARD)) state_next = ST_LI;
        if (accept && (req.req_type == REQ_BACKWARD)) state_next = ST_CLR;
      end
      ST_LI:    state_next = ST_LJ;
      ST_LJ:    state_next = ST_SIM;
      ST_SIM: begin
        if (!bwd) state_next = ST_FRD;
        else if (sim_now) state_next = ST_BRD;
        else begin
          u_go       = 1'b1;
          u_op       = ITU_SQRT;
          u_a        = {dsq_q, 24'd0};
          state_next = ST_SQW;
        end
      end
      ST_FRD:   state_next = ST_FMUL;
      ST_FMUL:  state_next = ST_FADD;
      ST_FADD:  state_next = k_last ? ST_FST : ST_FRD;
      ST_FST: begin
        if (similar) state_next = ST_NEXT;
        else begin
          u_go       = 1'b1;
          u_op       = ITU_SQRT;
          u_a        = {acc, 24'd0};
          state_next = ST_SQW;
        end
      end
      ST_SQW:   if (u_done) state_next = ST_GAP;
      ST_GAP: begin
        if ({4'd0, m24} > dist_q) state_next = bwd ? ST_BDEN : ST_FGSQ;
        else state_next = ST_NEXT;
      end
      ST_FGSQ:  state_next = ST_FGADD;
      ST_FGADD: state_next = ST_NEXT;
      ST_BDEN:  state_next = ST_BDEN2;
      ST_BDEN2: state_next = ST_BRD;
      ST_BRD:   state_next = ST_BD;
      ST_BD:    state_next = ST_BM;
      ST_BM:    state_next = ST_BDIV;
      ST_BDIV: begin
        u_go       = 1'b1;
        u_a        = num;
        u_b        = den;
        state_next = ST_BDW;
      end
      ST_BDW:   if (u_done) state_next = ST_BACC;
      ST_BACC:  state_next = k_last ? ST_NEXT : ST_BRD;
      ST_NEXT: begin
        if (i_last && j_last) begin
          if (bwd) state_next = ST_IDLE;
          else begin
            u_go       = 1'b1;
            u_a        = sum;
            u_b        = 64'({n_eff, 1'b0});
            state_next = ST_LDW;
          end
        end else begin
          state_next = ST_LI;
        end
      end
      ST_LDW:   if (u_done) state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      i        <= '0;
      j        <= '0;
      k        <= '0;
      clr_addr <= '0;
      bwd      <= 1'b0;
      rd_pend  <= 1'b0;
      done     <= 1'b0;
    end else begin
      done    <= 1'b0;
      rd_pend <= 1'b0;
      if (rd_pend) begin
        done               <= 1'b1;
        res.is_loss        <= 1'b0;
        res.loss_value     <= '0;
        res.gradient_value <= !rd_inside ? 32'd0 : (rd_txt ? tg_q : ig_q);
      end
      case (state)
        ST_CLR: clr_addr <= clr_last ? '0 : clr_addr + AW'(1);
        ST_IDLE: begin
          if (accept) begin
            unique case (req.req_type)
              REQ_FORWARD: begin
                i   <= '0;
                j   <= '0;
                sum <= '0;
                bwd <= 1'b0;
              end
              REQ_BACKWARD: begin
                i     <= '0;
                j     <= '0;
                bwd   <= 1'b1;
                s_neg <= req.value[15];
                s_abs <= req.value[15] ? 16'(-req.value) : req.value;
              end
              REQ_READ_IMG, REQ_READ_TXT: begin
                rd_pend   <= 1'b1;
                rd_txt    <= (req.req_type == REQ_READ_TXT);
                rd_inside <= in_range;
              end
              default: ;
            endcase
          end
        end
        ST_LJ: lab_i <= lab_q;
        ST_SIM: begin
          similar <= sim_now;
          k       <= '0;
          acc     <= '0;
          den     <= 64'(n_eff) << 12;
        end
        ST_FMUL:  prod <= 64'(sq);
        ST_FADD: begin
          acc <= acc_sat;
          k   <= k + KW'(1);
        end
        ST_FST:   if (similar) sum <= sum + 64'(acc);
        ST_SQW:   if (u_done) dist_q <= u_y[31:0];
        ST_GAP:   gap <= m24 - dist_q[27:0];
        ST_FGSQ:  prod <= 64'(gap * gap);
        ST_FGADD: sum <= sum + (prod >> 24);
        ST_BDEN:  prod <= 64'(n_eff * ({1'b0, dist_q} + EPS_Q24));
        ST_BDEN2: begin
          den <= prod << 12;
          k   <= '0;
        end
        ST_BD: begin
          d_neg <= d[16];
          prod  <= 64'(s_abs * da);
        end
        ST_BM:    num <= similar ? (prod << 1) : 64'(prod[33:0] * gap) << 1;
        ST_BDW:   if (u_done) tq <= u_y;
        ST_BACC:  k <= k + KW'(1);
        ST_NEXT: begin
          if (j_last) begin
            j <= '0;
            i <= i + IW'(1);
          end else begin
            j <= j + IW'(1);
          end
        end
        ST_LDW: begin
          if (u_done) begin
            done               <= 1'b1;
            res.is_loss        <= 1'b1;
            res.loss_value     <= (|u_y[63:48]) ? '1 : u_y[47:0];
            res.gradient_value <= '0;
          end
        end
        default: ;
      endcase
    end
  end

endmodule
